FILE: rtl/rwsb_pkg.sv
package rwsb_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_REPLICAS_DEF  = 16;
   localparam int BACKOFF_LIMIT_DEF = 10;

   // First retry delay in ms, doubled per back-off level
   localparam logic [31:0] RETRY_BASE_MS = 32'd1000;

   // Port widths
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int SIZE_W     = 5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_SIZE  = 1'b1;

   typedef enum logic [1:0] {
      MODE_SELECT  = 2'd0,
      MODE_FAIL    = 2'd1,
      MODE_SUCCESS = 2'd2,
      MODE_LOAD    = 2'd3
   } mode_type;

   // One stored replica entry
   typedef struct packed {
      logic [31:0] last_fail;
      logic [3:0]  level;
      logic [7:0]  errors;
      logic [7:0]  conns;
      logic [7:0]  weight;
   } entry_type;

   function automatic logic [31:0] retry_wait(input logic [3:0] level);
      return RETRY_BASE_MS << level;
   endfunction

endpackage

FILE: rtl/rwsb_ram.sv
module rwsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/replica_weighted_select_backoff.sv
// Replica selector: weighted round robin over a high and a low priority group,
// with exponential back-off for failing replicas.
//
// req_ channel: one word per request. tuser carries the mode (select, failure
// report, success report, load entry); tdata the target and the time stamp.
// rsp_ channel: exactly one word per request. tuser is the found flag, tdata
// the chosen group and index (zero unless found).
// csr_ port: group sizes; the user must write them only while the block is idle (not enforced by the block).
//
// Timing: one request at a time; req_tready is high only in the idle state.
// Reports and loads: one read-modify-write of the entry RAM (ST_RMW), then the
// response word is loaded (ST_DONE) and the block returns to idle. A select
// works per group: a set-up step, then the scan pointer is folded into range
// by repeated subtraction and the RAM read is started, then one entry per
// cycle for at most size+1 entries; an empty group is skipped in the set-up
// step. The pointer never exceeds 16. The single RAM read port and shared
// entry evaluation set this pace.
//
// Reset clears both group sizes, scan pointers and run counts and the per-entry
// valid bits; an entry never written reads as all zero, so no clearing pass.
// A stalled receiver holds the response word in the output register; the next
// request is still accepted and finishes once the register is free.
module replica_weighted_select_backoff #(
   parameter int MAX_REPLICAS  = rwsb_pkg::MAX_REPLICAS_DEF,
   parameter int BACKOFF_LIMIT = rwsb_pkg::BACKOFF_LIMIT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] group, [4:1] entry_index, [12:5] entry_weight,
   // [20:13] entry_connections, [52:21] now_ms, [55:53] zero
   input  logic [rwsb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] mode
   input  logic [rwsb_pkg::REQ_USER_W-1:0]  req_tuser,
   // response words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] chosen_group, [4:1] chosen_index, [7:5] zero
   output logic [rwsb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] found
   output logic [rwsb_pkg::RSP_USER_W-1:0]  rsp_tuser,
   // register writes
   input  logic                             csr_wr_en,
   input  logic [rwsb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rwsb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rwsb_pkg::*;

   localparam int ENTRIES = 2 * MAX_REPLICAS;
   localparam int AW      = $clog2(ENTRIES);
   localparam int EW      = $bits(entry_type);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_RMW   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // Group base plus index within group
   function automatic logic [AW-1:0] ent_addr(input logic g, input logic [4:0] x);
      logic [AW-1:0] base;
      base = g ? AW'(MAX_REPLICAS) : '0;
      return base + AW'(x);
   endfunction

   state_type state_ff, state_in;

   // captured request
   mode_type     mode_ff, mode_in;
   logic         grp_ff, grp_in;
   logic [3:0]   ix_ff, ix_in;
   logic [7:0]   wgt_ff, wgt_in;
   logic [7:0]   conn_ff, conn_in;
   logic [31:0]  now_ff, now_in;

   // configuration
   logic [SIZE_W-1:0] hi_size_ff, hi_size_in;
   logic [SIZE_W-1:0] lo_size_ff, lo_size_in;

   // per-group scan state
   logic [4:0] ptr_ff [2];
   logic [4:0] ptr_in [2];
   logic [7:0] run_ff [2];
   logic [7:0] run_in [2];

   // scan sequencer
   logic       g_ff, g_in;
   logic [4:0] cur_ff, cur_in;       // pointer being folded into range
   logic [4:0] vis_ff, vis_in;       // index whose data is on the RAM output
   logic [4:0] nxt_ff, nxt_in;       // index being read
   logic [4:0] visits_ff, visits_in;

   // result
   logic       res_found_ff, res_found_in;
   logic       res_grp_ff, res_grp_in;
   logic [3:0] res_idx_ff, res_idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_found_ff, rsp_found_in;
   logic       rsp_grp_ff, rsp_grp_in;
   logic [3:0] rsp_idx_ff, rsp_idx_in;

   // entry RAM and valid bits
   logic [ENTRIES-1:0] vld_ff, vld_in;
   logic               rd_vld_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   entry_type          wr_data;
   logic [EW-1:0]      rd_raw;
   entry_type          ent;

   logic [SIZE_W-1:0]  size_sel;
   logic [4:0]         n;
   logic               req_fire;
   logic               healthy, retry;

   rwsb_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // never-written entries read as zero
   assign ent = rd_vld_ff ? entry_type'(rd_raw) : '0;

   // group size, capped at the group depth (MAX_REPLICAS)
   assign size_sel = g_ff ? lo_size_ff : hi_size_ff;
   assign n = (int'(size_sel) > MAX_REPLICAS) ? 5'(MAX_REPLICAS) : size_sel;

   // entry evaluation shared by every scan step
   assign healthy = (run_ff[g_ff] < ent.weight) && (ent.errors < ent.conns);
   assign retry   = (ent.errors >= ent.conns) && (ent.level < 4'(BACKOFF_LIMIT)) &&
                    ((now_ff - ent.last_fail) > retry_wait(ent.level));

   always_comb begin
      entry_type  mod_ent;
      logic [7:0] err_inc;

      state_in     = state_ff;
      mode_in      = mode_ff;
      grp_in       = grp_ff;
      ix_in        = ix_ff;
      wgt_in       = wgt_ff;
      conn_in      = conn_ff;
      now_in       = now_ff;
      hi_size_in   = hi_size_ff;
      lo_size_in   = lo_size_ff;
      ptr_in       = ptr_ff;
      run_in       = run_ff;
      g_in         = g_ff;
      cur_in       = cur_ff;
      vis_in       = vis_ff;
      nxt_in       = nxt_ff;
      visits_in    = visits_ff;
      res_found_in = res_found_ff;
      res_grp_in   = res_grp_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_grp_in   = rsp_grp_ff;
      rsp_idx_in   = rsp_idx_ff;
      vld_in       = vld_ff;
      rd_addr      = ent_addr(g_ff, nxt_ff);
      wr_en        = 1'b0;
      wr_addr      = ent_addr(grp_ff, {1'b0, ix_ff});
      wr_data      = ent;
      mod_ent      = ent;
      err_inc      = (ent.errors == 8'hFF) ? ent.errors : ent.errors + 8'd1;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HIGH_SIZE: hi_size_in = csr_wdata;
            CSR_LOW_SIZE:  lo_size_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // read issued straight from the request for reports and loads
            rd_addr = ent_addr(req_tdata[0], {1'b0, req_tdata[4:1]});
            if (req_fire) begin
               mode_in      = mode_type'(req_tuser[1:0]);
               grp_in       = req_tdata[0];
               ix_in        = req_tdata[4:1];
               wgt_in       = req_tdata[12:5];
               conn_in      = req_tdata[20:13];
               now_in       = req_tdata[52:21];
               res_found_in = 1'b0;
               res_grp_in   = 1'b0;
               res_idx_in   = 4'd0;
               g_in         = 1'b0;
               if (mode_type'(req_tuser[1:0]) == MODE_SELECT) begin
                  state_in = ST_SETUP;
               end else if (int'(req_tdata[4:1]) < MAX_REPLICAS) begin
                  state_in = ST_RMW;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SETUP: begin
            if (n == 5'd0) begin
               // empty group: skipped, pointer and run count kept
               if (!g_ff) begin
                  g_in = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cur_in   = ptr_ff[g_ff];
               state_in = ST_MOD;
            end
         end

         ST_MOD: begin
            if (cur_ff >= n) begin
               cur_in = cur_ff - n;
            end else begin
               rd_addr   = ent_addr(g_ff, cur_ff);
               vis_in    = cur_ff;
               nxt_in    = (cur_ff + 5'd1 == n) ? 5'd0 : cur_ff + 5'd1;
               visits_in = 5'd0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // next entry is read while this one is judged
            vis_in    = nxt_ff;
            nxt_in    = (nxt_ff + 5'd1 == n) ? 5'd0 : nxt_ff + 5'd1;
            visits_in = visits_ff + 5'd1;
            if (healthy) begin
               run_in[g_ff] = run_ff[g_ff] + 8'd1;
               ptr_in[g_ff] = vis_ff;
               res_found_in = 1'b1;
               res_grp_in   = g_ff;
               res_idx_in   = vis_ff[3:0];
               state_in     = ST_DONE;
            end else begin
               run_in[g_ff] = 8'd0;
               if (retry) begin
                  // back-off expired: retry once, clear its error count
                  ptr_in[g_ff]   = vis_ff + 5'd1;
                  mod_ent.errors = 8'd0;
                  wr_en          = 1'b1;
                  wr_addr        = ent_addr(g_ff, vis_ff);
                  wr_data        = mod_ent;
                  vld_in[wr_addr] = 1'b1;
                  res_found_in   = 1'b1;
                  res_grp_in     = g_ff;
                  res_idx_in     = vis_ff[3:0];
                  state_in       = ST_DONE;
               end else if (visits_ff == n) begin
                  // group exhausted: pointer left on the last entry scanned
                  ptr_in[g_ff] = vis_ff;
                  if (!g_ff) begin
                     g_in     = 1'b1;
                     state_in = ST_SETUP;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end

         ST_RMW: begin
            unique case (mode_ff)
               MODE_FAIL: begin
                  mod_ent.errors = err_inc;
                  if ((err_inc >= ent.conns) && (ent.level < 4'(BACKOFF_LIMIT))) begin
                     mod_ent.level     = ent.level + 4'd1;
                     mod_ent.last_fail = now_ff;
                  end
               end
               MODE_SUCCESS: begin
                  mod_ent.errors = 8'd0;
                  mod_ent.level  = 4'd0;
               end
               MODE_LOAD: begin
                  mod_ent.weight = wgt_ff;
                  mod_ent.conns  = conn_ff;
               end
               MODE_SELECT: ;
            endcase
            wr_en           = 1'b1;
            wr_data         = mod_ent;
            vld_in[wr_addr] = 1'b1;
            state_in        = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_grp_in   = res_grp_ff;
               rsp_idx_in   = res_idx_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hi_size_ff   <= '0;
         lo_size_ff   <= '0;
         ptr_ff[0]    <= 5'd0;
         ptr_ff[1]    <= 5'd0;
         run_ff[0]    <= 8'd0;
         run_ff[1]    <= 8'd0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         hi_size_ff   <= hi_size_in;
         lo_size_ff   <= lo_size_in;
         ptr_ff       <= ptr_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      grp_ff       <= grp_in;
      ix_ff        <= ix_in;
      wgt_ff       <= wgt_in;
      conn_ff      <= conn_in;
      now_ff       <= now_in;
      g_ff         <= g_in;
      cur_ff       <= cur_in;
      vis_ff       <= vis_in;
      nxt_ff       <= nxt_in;
      visits_ff    <= visits_in;
      res_found_ff <= res_found_in;
      res_grp_ff   <= res_grp_in;
      res_idx_ff   <= res_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_grp_ff   <= rsp_grp_in;
      rsp_idx_ff   <= rsp_idx_in;
      // valid bit travels with the registered RAM read
      rd_vld_ff    <= vld_ff[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_idx_ff, rsp_grp_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

FILE: tb/sv/tb_replica_weighted_select_backoff.sv
`timescale 1ns / 100ps

module tb_replica_weighted_select_backoff;
   import rwsb_pkg::*;

   localparam int MAX_REP     = MAX_REPLICAS_DEF;
   localparam int BACKOFF_LIM = BACKOFF_LIMIT_DEF;
   localparam int ENTRIES     = 2 * MAX_REP;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 145;
   localparam int HOLD_CYCLES = 300;
   localparam int PRINT_CAP   = 100;

   // one request word, unpacked
   typedef struct {
      mode_type    mode;
      logic        grp;
      logic [3:0]  idx;
      logic [7:0]  wt;
      logic [7:0]  conns;
      logic [31:0] now;
   } req_word_type;

   // one response word, unpacked
   typedef struct {
      logic       found;
      logic       grp;
      logic [3:0] idx;
   } pick_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      req_word_type           w;
      bit                     none_typed;   // expected response typed in: nothing chosen
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
   } stim_row_type;

   // ---------------------------------------------------------------------------
   // DUT ports; every input known from time zero
   // ---------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   replica_weighted_select_backoff u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Shadow of the selector state
   // ---------------------------------------------------------------------------
   logic [7:0]  sh_weight [ENTRIES];
   logic [7:0]  sh_conns  [ENTRIES];
   logic [7:0]  sh_errors [ENTRIES];
   logic [3:0]  sh_level  [ENTRIES];
   logic [31:0] sh_last   [ENTRIES];
   logic [4:0]  sh_ptr    [2];
   logic [7:0]  sh_run    [2];
   logic [4:0]  sh_size   [2];

   pick_type pick_queue[$];   // expected response words, oldest first

   int  mismatches  = 0;
   int  words_sent  = 0;
   int  selects     = 0;
   int  picks_seen  = 0;
   int  settings    = 0;
   bit  quiet       = 1'b0;   // no idling on either side
   int  hold_req    = 0;      // long hold-offs asked for by the sender
   int  hold_done   = 0;      // long hold-offs started by the receiver
   int  hold_left   = 0;
   int  stall_left  = 0;
   logic [31:0] t_now = '0;

   function automatic int eff_size(logic [4:0] sz);
      return (sz > MAX_REP) ? MAX_REP : int'(sz);
   endfunction

   // One group's weighted round-robin scan; updates pointer, run count, errors.
   function automatic bit scan_group(int g, logic [31:0] now, output logic [3:0] pick);
      int          n;
      int          i;
      int          slot;
      int          e;
      logic [31:0] elapsed;
      logic [63:0] retry_ms;
      n    = eff_size(sh_size[g]);
      slot = 0;
      pick = '0;
      if (n == 0) return 1'b0;   // empty group: pointer and count untouched
      for (i = 0; i < n + 1; i++) begin
         slot = (i + int'(sh_ptr[g]) + n) % n;
         e    = g * MAX_REP + slot;
         // healthy: keep serving it up to its weight
         if (sh_run[g] < sh_weight[e] && sh_errors[e] < sh_conns[e]) begin
            sh_run[g] = sh_run[g] + 8'd1;
            sh_ptr[g] = 5'(slot);
            pick      = 4'(slot);
            return 1'b1;
         end
         sh_run[g] = '0;
         // failed but back-off not exhausted: retry once the wait is over
         if (sh_errors[e] >= sh_conns[e] && sh_level[e] < BACKOFF_LIM) begin
            retry_ms = {32'd0, RETRY_BASE_MS} << sh_level[e];
            elapsed  = now - sh_last[e];
            if ({32'd0, elapsed} > retry_ms) begin
               sh_ptr[g]    = 5'(slot + 1);
               sh_errors[e] = '0;
               pick         = 4'(slot);
               return 1'b1;
            end
         end
      end
      sh_ptr[g] = 5'(slot);
      return 1'b0;
   endfunction

   function automatic pick_type predict_pick(req_word_type w);
      pick_type   p;
      logic [3:0] slot;
      int         e;
      int         g;
      p = '{1'b0, 1'b0, 4'd0};
      e = int'(w.grp) * MAX_REP + int'(w.idx);
      if (w.mode == MODE_SELECT) begin
         for (g = 0; g < 2; g++) begin
            if (scan_group(g, w.now, slot)) begin
               p = '{1'b1, 1'(g), slot};
               break;
            end
         end
      end else if (int'(w.idx) < MAX_REP) begin
         unique case (w.mode)
            MODE_FAIL: begin
               if (sh_errors[e] != 8'hFF) sh_errors[e] = sh_errors[e] + 8'd1;
               if (sh_errors[e] >= sh_conns[e] && sh_level[e] < BACKOFF_LIM) begin
                  sh_level[e] = sh_level[e] + 4'd1;
                  sh_last[e]  = w.now;
               end
            end
            MODE_SUCCESS: begin
               sh_errors[e] = '0;
               sh_level[e]  = '0;
            end
            default: begin
               sh_weight[e] = w.wt;
               sh_conns[e]  = w.conns;
            end
         endcase
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < PRINT_CAP)
         $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------
   // Offers one word and returns at the edge that accepts it, valid still high.
   task automatic send_word(req_word_type w, bit none_typed);
      pick_type p;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.mode;
      req_tdata  <= {3'b000, w.now, w.conns, w.wt, w.idx, w.grp};
      do @(posedge clock); while (!req_tready);
      p = predict_pick(w);
      if (none_typed) p = '{1'b0, 1'b0, 4'd0};
      pick_queue.push_back(p);
      words_sent++;
      if (w.mode == MODE_SELECT) selects++;
   endtask

   // Drains the block before a register write.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pick_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] ix, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= ix;
      csr_wdata <= val;
      @(posedge clock);
      sh_size[ix] = val;
      settings++;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_type word_row(mode_type m, logic g, logic [3:0] i,
                                             logic [7:0] wt, logic [7:0] c,
                                             logic [31:0] now, bit none_typed);
      stim_row_type r;
      r.kind       = ROW_WORD;
      r.w.mode     = m;
      r.w.grp      = g;
      r.w.idx      = i;
      r.w.wt       = wt;
      r.w.conns    = c;
      r.w.now      = now;
      r.none_typed = none_typed;
      r.csr_idx    = '0;
      r.csr_val    = '0;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] ix,
                                            logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r         = word_row(MODE_SELECT, 1'b0, 4'd0, 8'd0, 8'd0, 32'd0, 1'b0);
      r.kind    = ROW_CSR;
      r.csr_idx = ix;
      r.csr_val = val;
      return r;
   endfunction

   // Random word, biased towards entries inside the configured groups and
   // towards small weights and connection counts so failures bite.
   function automatic req_word_type random_word();
      req_word_type w;
      int           r;
      int           n;
      r = $urandom_range(0, 99);
      if (r < 50)      w.mode = MODE_SELECT;
      else if (r < 68) w.mode = MODE_FAIL;
      else if (r < 78) w.mode = MODE_SUCCESS;
      else             w.mode = MODE_LOAD;
      w.grp = 1'($urandom_range(0, 1));
      n     = eff_size(sh_size[w.grp]);
      if (n > 0 && $urandom_range(0, 4) != 0) w.idx = 4'($urandom_range(0, n - 1));
      else                                    w.idx = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r < 6)       w.wt = 8'($urandom_range(0, 3));
      else if (r < 8)  w.wt = 8'($urandom_range(4, 20));
      else if (r < 9)  w.wt = 8'hFF;
      else             w.wt = 8'($urandom);
      r = $urandom_range(0, 9);
      if (r < 5)       w.conns = 8'($urandom_range(0, 3));
      else if (r < 8)  w.conns = 8'($urandom_range(0, 10));
      else             w.conns = 8'($urandom);
      // time mostly creeps forward, sometimes leaps past long back-offs,
      // now and then lands anywhere (wrap-around of the difference)
      r = $urandom_range(0, 99);
      if (r < 92)      t_now = t_now + 32'($urandom_range(0, 1500));
      else if (r < 97) t_now = t_now + 32'($urandom_range(0, 600000));
      else             t_now = $urandom;
      w.now = t_now;
      return w;
   endfunction

   stim_row_type directed[$];

   initial begin : stimulus
      int           k;
      int           ph;
      int           g;
      int           i;
      int           cnt;
      req_word_type w;
      logic [4:0] ph_high [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3,
                                       5'd16, 5'd0, 5'd2, 5'd0, 5'd0};
      logic [4:0] ph_low  [PHASES] = '{5'd16, 5'd0, 5'd1, 5'd5, 5'd16,
                                       5'd0, 5'd0, 5'd2, 5'd0, 5'd0};

      for (k = 0; k < ENTRIES; k++) begin
         sh_weight[k] = '0;
         sh_conns[k]  = '0;
         sh_errors[k] = '0;
         sh_level[k]  = '0;
         sh_last[k]   = '0;
      end
      sh_ptr  = '{5'd0, 5'd0};
      sh_run  = '{8'd0, 8'd0};
      sh_size = '{5'd0, 5'd0};

      // -- directed table --------------------------------------------------------
      // both groups empty after reset: nothing to choose
      directed.push_back(word_row(MODE_SELECT, 1'b0, 4'd0, 8'd0, 8'd0, 32'd0, 1'b1));
      // loads at the field extremes; reports and loads never choose anything
      directed.push_back(word_row(MODE_LOAD, 1'b0, 4'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1));
      directed.push_back(word_row(MODE_LOAD, 1'b0, 4'd1, 8'd1, 8'd0, 32'd0, 1'b1));
      directed.push_back(word_row(MODE_LOAD, 1'b1, 4'd15, 8'd0, 8'd0, 32'd0, 1'b1));
      directed.push_back(word_row(MODE_LOAD, 1'b1, 4'd0, 8'd2, 8'd1, 32'd0, 1'b1));
      // oversized high group, empty low group
      directed.push_back(csr_row(CSR_HIGH_SIZE, 5'd31));
      directed.push_back(csr_row(CSR_LOW_SIZE, 5'd0));
      directed.push_back(word_row(MODE_SELECT, 1'b0, 4'd0, 8'd0, 8'd0, 32'd0, 1'b0));
      directed.push_back(word_row(MODE_SELECT, 1'b1, 4'd15, 8'hFF, 8'hFF, 32'd0, 1'b0));
      directed.push_back(word_row(MODE_FAIL, 1'b0, 4'd0, 8'd0, 8'd0, 32'd10, 1'b1));
      directed.push_back(word_row(MODE_SUCCESS, 1'b0, 4'd0, 8'd0, 8'd0, 32'd20, 1'b1));
      directed.push_back(word_row(MODE_FAIL, 1'b0, 4'd1, 8'd0, 8'd0, 32'd100, 1'b1));
      // empty high group skipped, full low group scanned; retry after the wait
      directed.push_back(csr_row(CSR_HIGH_SIZE, 5'd0));
      directed.push_back(csr_row(CSR_LOW_SIZE, 5'd16));
      directed.push_back(word_row(MODE_SELECT, 1'b0, 4'd0, 8'd0, 8'd0, 32'd50, 1'b0));
      directed.push_back(word_row(MODE_SELECT, 1'b0, 4'd0, 8'd0, 8'd0, 32'd3000, 1'b0));
      // run an entry's back-off all the way to the limit
      for (k = 0; k < BACKOFF_LIM; k++)
         directed.push_back(word_row(MODE_FAIL, 1'b1, 4'd15, 8'd0, 8'd0,
                                     32'h8000_0000 + 32'(k), 1'b1));
      directed.push_back(csr_row(CSR_HIGH_SIZE, 5'd2));
      directed.push_back(word_row(MODE_SELECT, 1'b0, 4'd0, 8'd0, 8'd0, 32'h7FFF_FFFF, 1'b0));
      // success report revives the exhausted entry
      directed.push_back(word_row(MODE_SUCCESS, 1'b1, 4'd15, 8'd0, 8'd0, 32'd0, 1'b1));
      directed.push_back(word_row(MODE_SELECT, 1'b1, 4'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 1'b0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < directed.size(); k++) begin
         if (directed[k].kind == ROW_CSR) begin
            settle_idle();
            write_csr(directed[k].csr_idx, directed[k].csr_val);
         end else begin
            send_word(directed[k].w, directed[k].none_typed);
         end
      end

      // -- random phases: reload the groups, then mixed traffic -------------------
      for (ph = 0; ph < PHASES; ph++) begin
         settle_idle();
         if (ph >= PHASES - 2) begin
            ph_high[ph] = 5'($urandom_range(1, 16));
            ph_low[ph]  = 5'($urandom_range(0, 20));
         end
         write_csr(CSR_HIGH_SIZE, ph_high[ph]);
         write_csr(CSR_LOW_SIZE, ph_low[ph]);
         quiet = (ph == PHASES - 1);
         cnt   = 0;
         for (g = 0; g < 2; g++) begin
            for (i = 0; i < eff_size(sh_size[g]); i++) begin
               w       = random_word();
               w.mode  = MODE_LOAD;
               w.grp   = 1'(g);
               w.idx   = 4'(i);
               send_word(w, 1'b0);
               cnt++;
            end
         end
         while (cnt < PHASE_WORDS) begin
            // long receiver hold-off mid-phase: the block backs up into req_
            if (ph == 3 && cnt == PHASE_WORDS / 2) hold_req++;
            send_word(random_word(), 1'b0);
            cnt++;
         end
      end

      // -- wind-down ---------------------------------------------------------------
      req_tvalid <= 1'b0;
      for (k = 0; k < 20000 && pick_queue.size() != 0; k++) @(posedge clock);
      repeat (60) @(posedge clock);
      if (pick_queue.size() != 0)
         report_mismatch("responses still outstanding", 0, pick_queue.size());

      $display("Sent %0d request words, %0d of them selects; %0d responses chose a replica.",
               words_sent, selects, picks_seen);
      $display("Group sizes were set %0d times, including empty and oversized groups.",
               settings);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver side: check each response word, then decide next cycle's tready
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser[0]) picks_seen++;
         if (pick_queue.size() == 0) begin
            report_mismatch("response with none outstanding", rsp_tdata, 0);
         end else begin
            want = pick_queue.pop_front();
            if (rsp_tuser[0] !== want.found)
               report_mismatch("found", rsp_tuser[0], want.found);
            if (rsp_tdata[0] !== want.grp)
               report_mismatch("chosen_group", rsp_tdata[0], want.grp);
            if (rsp_tdata[4:1] !== want.idx)
               report_mismatch("chosen_index", rsp_tdata[4:1], want.idx);
         end
      end

      if (hold_req != hold_done) begin
         hold_done = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: far beyond the slowest correct run
   initial begin : watchdog
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
